@@ rtl/tsm_pkg.sv @@
package tsm_pkg;

  // Storage geometry
  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DATA_W  = 32;

  // Configuration port
  localparam int LEN_W   = 11;
  localparam int ADDR_W  = 2;
  localparam int PDATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_LIST_LENGTH   = ADDR_W'(0);
  localparam logic [LEN_W-1:0]  LIST_LENGTH_RESET = 11'd1024;

  // Input item kinds
  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_FETCH       = 2'd2;

  // Result status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FETCH_NOT_READY,
    FETCH_EXHAUSTED,
    FETCH_MERGE
  } fetch_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     status;
  } result_t;

endpackage

@@ rtl/two_way_sorted_merge.sv @@
// Two-way merge of ascending lists of signed 32-bit words.
// Input channel (in_valid/in_stall, kind, value): kind 0 loads the next
// element of the first list, kind 1 of the second list, kind 2 fetches the
// next merged element. Loads past list_length and kind 3 are dropped and
// give no result. Each fetch gives exactly one result transaction on the
// output channel (out_valid/out_stall, merged_value, last_of_merge, status).
// status 1 means the lists are not both full yet, or both read out (value, last 0).
// last_of_merge marks the final element; the block then clears its counts
// and pointers and is ready for a new pair of lists.
// Loads are accepted back to back while the engine idles; a fetch moves the
// engine to its emit state, where, after the registered read of both list
// heads, it does the compare and pointer update and pushes the result into
// the output register; in_stall stays high, and no new input is accepted,
// until the engine is back in idle.
// While the output register holds an untaken result under out_stall, a
// fetch waits in its compare cycle and in_stall stays high until it drains.
// Reset (rst, synchronous) clears counts, pointers, and sets list_length to
// 1024; list storage is not cleared, and only written entries are ever read.
// list_length sits at APB byte address 0; the user writes it only while the block idles, unenforced.
module two_way_sorted_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsm_pkg::ADDR_W-1:0]         paddr,
  input  logic [tsm_pkg::PDATA_W-1:0]        pwdata,
  output logic [tsm_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic signed [tsm_pkg::DATA_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tsm_pkg::DATA_W-1:0]  merged_value,
  output logic                               last_of_merge,
  output logic                               status
);

  logic [tsm_pkg::CNT_W-1:0] eff_len;
  logic                      res_free;
  logic                      res_push;
  tsm_pkg::result_t          res;

  tsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_len (eff_len)
  );

  tsm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .eff_len  (eff_len),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .value    (value),
    .res_free (res_free),
    .res_push (res_push),
    .res      (res)
  );

  tsm_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_push      (res_push),
    .res           (res),
    .res_free      (res_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .merged_value  (merged_value),
    .last_of_merge (last_of_merge),
    .status        (status)
  );

endmodule

@@ rtl/tsm_cfg.sv @@
module tsm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsm_pkg::ADDR_W-1:0]    paddr,
  input  logic [tsm_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [tsm_pkg::CNT_W-1:0]     eff_len
);

  logic [tsm_pkg::LEN_W-1:0] list_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= tsm_pkg::LIST_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == tsm_pkg::REG_LIST_LENGTH) begin
      list_length <= pwdata[tsm_pkg::LEN_W-1:0];
    end
  end

  assign pready = 1'b1;

  always_comb begin
    if (paddr == tsm_pkg::REG_LIST_LENGTH) begin
      prdata = tsm_pkg::PDATA_W'(list_length);
    end else begin
      prdata = '0;
    end
  end

  // Zero acts as one, anything above the store depth acts as the depth
  always_comb begin
    if (list_length == '0) begin
      eff_len = tsm_pkg::CNT_W'(1);
    end else if (int'(list_length) > tsm_pkg::MAX_LEN) begin
      eff_len = tsm_pkg::CNT_W'(tsm_pkg::MAX_LEN);
    end else begin
      eff_len = tsm_pkg::CNT_W'(list_length);
    end
  end

endmodule

@@ rtl/tsm_engine.sv @@
module tsm_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tsm_pkg::CNT_W-1:0]         eff_len,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic signed [tsm_pkg::DATA_W-1:0] value,
  input  logic                              res_free,
  output logic                              res_push,
  output tsm_pkg::result_t                  res
);

  logic [tsm_pkg::DATA_W-1:0] first_mem  [tsm_pkg::MAX_LEN];
  logic [tsm_pkg::DATA_W-1:0] second_mem [tsm_pkg::MAX_LEN];
  logic [tsm_pkg::DATA_W-1:0] first_rdata;
  logic [tsm_pkg::DATA_W-1:0] second_rdata;

  tsm_pkg::state_t state;
  tsm_pkg::state_t state_next;
  tsm_pkg::fetch_t fetch_class;

  logic [tsm_pkg::CNT_W-1:0] first_loaded;
  logic [tsm_pkg::CNT_W-1:0] second_loaded;
  logic [tsm_pkg::CNT_W-1:0] first_rd_pos;
  logic [tsm_pkg::CNT_W-1:0] second_rd_pos;
  logic                      first_done;
  logic                      second_done;

  logic                      accept;
  logic                      load_first;
  logic                      load_second;
  logic                      fetch;
  logic                      take_first;
  logic [tsm_pkg::CNT_W-1:0] first_rd_after;
  logic [tsm_pkg::CNT_W-1:0] second_rd_after;
  logic                      merge_last;
  logic                      clear_job;

  assign accept      = in_valid && !in_stall;
  assign load_first  = accept && kind == tsm_pkg::KIND_LOAD_FIRST && first_loaded < eff_len;
  assign load_second = accept && kind == tsm_pkg::KIND_LOAD_SECOND && second_loaded < eff_len;
  assign fetch       = accept && kind == tsm_pkg::KIND_FETCH;

  // Memories: one write port fed by loads, one registered read port at the head
  always_ff @(posedge clk) begin
    if (load_first) begin
      first_mem[first_loaded[tsm_pkg::IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (load_second) begin
      second_mem[second_loaded[tsm_pkg::IDX_W-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    first_rdata  <= first_mem[first_rd_pos[tsm_pkg::IDX_W-1:0]];
    second_rdata <= second_mem[second_rd_pos[tsm_pkg::IDX_W-1:0]];
  end

  // Classify a fetch at acceptance; heads arrive from memory in the next cycle
  always_ff @(posedge clk) begin
    if (fetch) begin
      first_done  <= first_rd_pos >= eff_len;
      second_done <= second_rd_pos >= eff_len;
      if (first_loaded < eff_len || second_loaded < eff_len) begin
        fetch_class <= tsm_pkg::FETCH_NOT_READY;
      end else if (first_rd_pos >= eff_len && second_rd_pos >= eff_len) begin
        fetch_class <= tsm_pkg::FETCH_EXHAUSTED;
      end else begin
        fetch_class <= tsm_pkg::FETCH_MERGE;
      end
    end
  end

  // Equal heads favor the first list
  always_comb begin
    priority if (second_done) begin
      take_first = 1'b1;
    end else if (first_done) begin
      take_first = 1'b0;
    end else begin
      take_first = $signed(first_rdata) <= $signed(second_rdata);
    end
  end

  assign first_rd_after  = first_rd_pos + tsm_pkg::CNT_W'(take_first);
  assign second_rd_after = second_rd_pos + tsm_pkg::CNT_W'(!take_first);
  assign merge_last      = first_rd_after >= eff_len && second_rd_after >= eff_len;

  always_comb begin
    state_next = state;
    unique case (state)
      tsm_pkg::S_IDLE: begin
        if (fetch) begin
          state_next = tsm_pkg::S_EMIT;
        end
      end
      tsm_pkg::S_EMIT: begin
        if (res_free) begin
          state_next = tsm_pkg::S_IDLE;
        end
      end
      default: state_next = tsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    res_push   = 1'b0;
    clear_job  = 1'b0;
    res.value  = '0;
    res.last   = 1'b0;
    res.status = tsm_pkg::STATUS_NOT_READY;
    unique case (state)
      tsm_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      tsm_pkg::S_EMIT: begin
        res_push = res_free;
        unique case (fetch_class)
          tsm_pkg::FETCH_EXHAUSTED: begin
            clear_job = res_free;
          end
          tsm_pkg::FETCH_MERGE: begin
            res.value  = take_first ? first_rdata : second_rdata;
            res.last   = merge_last;
            res.status = tsm_pkg::STATUS_OK;
            clear_job  = res_free && merge_last;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tsm_pkg::S_IDLE;
      first_loaded  <= '0;
      second_loaded <= '0;
      first_rd_pos  <= '0;
      second_rd_pos <= '0;
    end else begin
      state <= state_next;
      if (clear_job) begin
        first_loaded  <= '0;
        second_loaded <= '0;
        first_rd_pos  <= '0;
        second_rd_pos <= '0;
      end else begin
        if (load_first) begin
          first_loaded <= first_loaded + tsm_pkg::CNT_W'(1);
        end
        if (load_second) begin
          second_loaded <= second_loaded + tsm_pkg::CNT_W'(1);
        end
        if (res_push && fetch_class == tsm_pkg::FETCH_MERGE) begin
          first_rd_pos  <= first_rd_after;
          second_rd_pos <= second_rd_after;
        end
      end
    end
  end

  a_rd_within_loaded: assert property (@(posedge clk) disable iff (rst)
    first_rd_pos <= first_loaded && second_rd_pos <= second_loaded)
    else $error("read pointer passed the loaded count");

  a_emit_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    state == tsm_pkg::S_EMIT |-> $past(state == tsm_pkg::S_EMIT) || $past(fetch))
    else $error("emit state entered without a fetch");

  a_push_returns_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |=> state == tsm_pkg::S_IDLE)
    else $error("engine did not return to idle after a result");

  a_last_clears_job: assert property (@(posedge clk) disable iff (rst)
    res_push && res.last |=> first_loaded == '0 && second_loaded == '0 &&
                             first_rd_pos == '0 && second_rd_pos == '0)
    else $error("job state not cleared after the final element");

endmodule

@@ rtl/tsm_out_reg.sv @@
module tsm_out_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               res_push,
  input  tsm_pkg::result_t                   res,
  output logic                               res_free,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tsm_pkg::DATA_W-1:0]  merged_value,
  output logic                               last_of_merge,
  output logic                               status
);

  tsm_pkg::result_t held;

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push && res_free) begin
      held <= res;
    end
  end

  assign merged_value  = held.value;
  assign last_of_merge = held.last;
  assign status        = held.status;

endmodule

@@ tb/sv/two_way_sorted_merge_tb.sv @@
`timescale 1ns / 1ps

module two_way_sorted_merge_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_CAP = 200;

  typedef enum {LIST_WIDE, LIST_NARROW, LIST_EDGES, LIST_SHUFFLED} list_shape_t;

  class merge_scoreboard;
    logic signed [tsm_pkg::DATA_W-1:0] first_list [tsm_pkg::MAX_LEN];
    logic signed [tsm_pkg::DATA_W-1:0] second_list [tsm_pkg::MAX_LEN];
    int unsigned first_count, second_count, first_pos, second_pos;
    logic [tsm_pkg::LEN_W-1:0] length_reg;
    tsm_pkg::result_t merged_q [$];
    int errors;

    function new();
      length_reg = tsm_pkg::LIST_LENGTH_RESET;
      errors = 0;
      clear_job();
    endfunction

    function void clear_job();
      first_count = 0;
      second_count = 0;
      first_pos = 0;
      second_pos = 0;
    endfunction

    function int unsigned active_length();
      if (length_reg == '0) return 1;
      if (length_reg > tsm_pkg::MAX_LEN) return tsm_pkg::MAX_LEN;
      return length_reg;
    endfunction

    task report_mismatch(input string what);
      if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    // Predict the result of one accepted input transaction.
    function void note_item(input logic [1:0] k,
                            input logic signed [tsm_pkg::DATA_W-1:0] v);
      int unsigned n;
      bit take_first;
      tsm_pkg::result_t r;
      n = active_length();
      case (k)
        tsm_pkg::KIND_LOAD_FIRST: begin
          if (first_count < n) begin
            first_list[first_count] = v;
            first_count++;
          end
        end
        tsm_pkg::KIND_LOAD_SECOND: begin
          if (second_count < n) begin
            second_list[second_count] = v;
            second_count++;
          end
        end
        tsm_pkg::KIND_FETCH: begin
          r.value = '0;
          r.last = 1'b0;
          r.status = tsm_pkg::STATUS_NOT_READY;
          if (first_count >= n && second_count >= n) begin
            if (first_pos >= n && second_pos >= n) begin
              clear_job();
            end else begin
              if (first_pos >= n) take_first = 1'b0;
              else if (second_pos >= n) take_first = 1'b1;
              else take_first = first_list[first_pos] <= second_list[second_pos];
              if (take_first) begin
                r.value = first_list[first_pos];
                first_pos++;
              end else begin
                r.value = second_list[second_pos];
                second_pos++;
              end
              r.status = tsm_pkg::STATUS_OK;
              if (first_pos >= n && second_pos >= n) begin
                r.last = 1'b1;
                clear_job();
              end
            end
          end
          merged_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task check_result(input logic signed [tsm_pkg::DATA_W-1:0] v, input logic l,
                      input logic s);
      tsm_pkg::result_t want;
      if (merged_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d last %b status %b", v, l, s));
      end else begin
        want = merged_q.pop_front();
        if (v !== want.value || l !== want.last || s !== want.status) begin
          report_mismatch($sformatf("value %0d last %b status %b, want %0d %b %b",
                                    v, l, s, want.value, want.last, want.status));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tsm_pkg::ADDR_W-1:0] paddr = '0;
  logic [tsm_pkg::PDATA_W-1:0] pwdata = '0;
  logic [tsm_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = tsm_pkg::KIND_LOAD_FIRST;
  logic signed [tsm_pkg::DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tsm_pkg::DATA_W-1:0] merged_value;
  logic last_of_merge;
  logic status;

  merge_scoreboard sb;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int job_len = tsm_pkg::MAX_LEN;

  two_way_sorted_merge u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_value(merged_value),
    .last_of_merge(last_of_merge),
    .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Note inputs before checking outputs so the order within an edge is fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(kind, value);
      if (out_valid && !out_stall) sb.check_result(merged_value, last_of_merge, status);
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [tsm_pkg::DATA_W-1:0] v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (sb.merged_q.size() != 0) @(posedge clk);
    // let a trailing load finish before touching the register
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [tsm_pkg::LEN_W-1:0] len);
    logic [tsm_pkg::PDATA_W-1:0] word;
    word = ($urandom & ~tsm_pkg::PDATA_W'(2 ** tsm_pkg::LEN_W - 1)) |
           tsm_pkg::PDATA_W'(len);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsm_pkg::REG_LIST_LENGTH;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.length_reg = len;
    // read back in a second transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[tsm_pkg::LEN_W-1:0] !== len) begin
      sb.report_mismatch($sformatf("list_length reads %0d, wrote %0d",
                                   prdata[tsm_pkg::LEN_W-1:0], len));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    job_len = sb.active_length();
  endtask

  task automatic make_list(input int cnt, input list_shape_t shape, output int vals [$]);
    vals = {};
    for (int i = 0; i < cnt; i++) begin
      case (shape)
        LIST_NARROW: vals.push_back(int'($urandom_range(0, 6)) - 3);
        LIST_EDGES: begin
          case ($urandom_range(0, 4))
            0: vals.push_back(int'(32'h8000_0000));
            1: vals.push_back(int'(32'h7FFF_FFFF));
            2: vals.push_back(0);
            3: vals.push_back(-1);
            default: vals.push_back($urandom);
          endcase
        end
        default: vals.push_back($urandom);
      endcase
    end
    if (shape != LIST_SHUFFLED) vals.sort();
  endtask

  // Interleave the two lists; sprinkle early fetches and unused kinds.
  task automatic load_lists(input int a [$], input int b [$], input int noise_pct);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item($urandom_range(0, 1) ? KIND_UNUSED : tsm_pkg::KIND_FETCH, $urandom);
      end
      if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1))) begin
        send_item(tsm_pkg::KIND_LOAD_FIRST, a[ia]);
        ia++;
      end else begin
        send_item(tsm_pkg::KIND_LOAD_SECOND, b[ib]);
        ib++;
      end
    end
  endtask

  // Complete a job after the length moved; call only while drained.
  task automatic finish_job();
    int n;
    int p1;
    int p2;
    int fetches;
    n = job_len;
    p1 = int'(sb.first_pos);
    p2 = int'(sb.second_pos);
    if (n > int'(sb.first_count)) repeat (n - int'(sb.first_count)) begin
      send_item(tsm_pkg::KIND_LOAD_FIRST, $urandom);
    end
    if (n > int'(sb.second_count)) repeat (n - int'(sb.second_count)) begin
      send_item(tsm_pkg::KIND_LOAD_SECOND, $urandom);
    end
    if (p1 >= n && p2 >= n) fetches = 1;
    else fetches = (p1 >= n ? 0 : n - p1) + (p2 >= n ? 0 : n - p2);
    repeat (fetches) send_item(tsm_pkg::KIND_FETCH, $urandom);
  endtask

  task automatic run_merge_job();
    int n;
    int r;
    int cut;
    int a [$];
    int b [$];
    list_shape_t shape;
    if (job_len > 64 || $urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 19);
      if (r < 14) n = $urandom_range(1, 6);
      else if (r < 19) n = $urandom_range(7, 24);
      else n = $urandom_range(25, 64);
      set_length((n == 1 && $urandom_range(0, 1)) ? '0 : tsm_pkg::LEN_W'(n));
    end
    n = job_len;
    r = $urandom_range(0, 9);
    shape = r < 5 ? LIST_WIDE : r < 7 ? LIST_NARROW : r < 9 ? LIST_EDGES : LIST_SHUFFLED;
    make_list(n + ($urandom_range(0, 9) == 0), shape, a);
    make_list(n + ($urandom_range(0, 9) == 0), shape, b);
    load_lists(a, b, 6);
    if (n > 1 && $urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, 2 * n - 1);
      repeat (cut) send_item(tsm_pkg::KIND_FETCH, $urandom);
      set_length(tsm_pkg::LEN_W'($urandom_range(0, n + 3)));
      finish_job();
    end else begin
      for (int i = 0; i < 2 * n; i++) begin
        if ($urandom_range(0, 99) < 5) begin
          send_item($urandom_range(0, 1) ? KIND_UNUSED : tsm_pkg::KIND_LOAD_FIRST,
                    $urandom);
        end
        send_item(tsm_pkg::KIND_FETCH, $urandom);
      end
      if ($urandom_range(0, 99) < 10) send_item(tsm_pkg::KIND_FETCH, $urandom);
    end
  endtask

  initial begin
    int first_vals [$];
    int second_vals [$];
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 28;
    stall_pct = 56;
    // nothing loaded yet under the reset length
    send_item(tsm_pkg::KIND_FETCH, 32'h0000_0000);
    // extremes at both ends, equal heads, one list running out first
    set_length(tsm_pkg::LEN_W'(2));
    send_item(tsm_pkg::KIND_LOAD_FIRST, 32'h8000_0000);
    send_item(tsm_pkg::KIND_FETCH, 32'hFFFF_FFFF);
    send_item(tsm_pkg::KIND_LOAD_FIRST, 32'd5);
    send_item(tsm_pkg::KIND_LOAD_FIRST, 32'd99);
    send_item(KIND_UNUSED, 32'h5A5A_5A5A);
    send_item(tsm_pkg::KIND_LOAD_SECOND, 32'd5);
    send_item(tsm_pkg::KIND_LOAD_SECOND, 32'h7FFF_FFFF);
    repeat (5) send_item(tsm_pkg::KIND_FETCH, $urandom);
    // zero length behaves as one
    set_length('0);
    send_item(tsm_pkg::KIND_LOAD_FIRST, 32'd7);
    send_item(tsm_pkg::KIND_LOAD_FIRST, 32'd8);
    send_item(tsm_pkg::KIND_LOAD_SECOND, -32'sd7);
    repeat (2) send_item(tsm_pkg::KIND_FETCH, $urandom);
    // lower the length under both read pointers mid-merge
    set_length(tsm_pkg::LEN_W'(3));
    for (int i = 0; i < 3; i++) begin
      send_item(tsm_pkg::KIND_LOAD_FIRST, 2 * i + 1);
      send_item(tsm_pkg::KIND_LOAD_SECOND, 2 * i + 2);
    end
    repeat (2) send_item(tsm_pkg::KIND_FETCH, $urandom);
    set_length(tsm_pkg::LEN_W'(1));
    repeat (2) send_item(tsm_pkg::KIND_FETCH, $urandom);

    while (items_sent < 380) run_merge_job();
    send_gap_pct = 56;
    stall_pct = 28;
    while (items_sent < 760) run_merge_job();
    send_gap_pct = 0;
    stall_pct = 0;
    while (items_sent < 1080) run_merge_job();

    // an oversize length keeps both lists open, so fetches stay not ready
    set_length('1);
    make_list(12, LIST_WIDE, first_vals);
    make_list(12, LIST_EDGES, second_vals);
    load_lists(first_vals, second_vals, 1);
    repeat (4) send_item(tsm_pkg::KIND_FETCH, $urandom);
    set_length(tsm_pkg::LEN_W'($urandom_range(1, 12)));
    finish_job();

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.merged_q.size() == 0) begin
      $display("two_way_sorted_merge_tb: done, clean");
    end else begin
      $display("two_way_sorted_merge_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("two_way_sorted_merge_tb: done, errors");
    $finish;
  end

endmodule
